// ----- hw/rtl/hass_pkg.sv -----
// Shared types, constants and microprogram of the SSB shifter.
`timescale 1ns / 1ps
`default_nettype none

package hass_pkg;

	// Default parameter values
	localparam int DEF_PHASE_BITS       = 32;
	localparam int DEF_SINE_TABLE_DEPTH = 256;
	localparam int DEF_INTERNAL_WIDTH   = 24;

	// Allpass sections: four per path, two paths
	localparam int NSECT     = 8;
	localparam int SEC_W     = 3;
	localparam int PATH_SECT = 4;
	localparam int COEF_BITS = 18;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 32;
	localparam int OUT_W    = 3 * SAMPLE_W;
	localparam int ROM_W    = 15;
	localparam int TRIG_W   = ROM_W + 2;

	// Q0.18 coefficients, round(a*a*2^18); path one first, then path two
	localparam logic [COEF_BITS-1:0] COEF [NSECT] = '{
		18'd125672, 18'd229695, 18'd256009, 18'd261488,
		18'd42404,  18'd192159, 18'd247818, 18'd259680
	};

	// pi/2 in Q30
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;

	// Microcode
	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOADX,
		OP_SECT_MUL,
		OP_SECT_FIN,
		OP_P1DONE,
		OP_ROM_LO,
		OP_ROM_HI,
		OP_TRIG_HI,
		OP_MUL_C,
		OP_MUL_S,
		OP_SUB,
		OP_OUT
	} uop_t;

	typedef enum logic [2:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_NO_ITEM,
		JC_PATH_NOT_DONE,
		JC_OUT_BUSY
	} jcond_t;

	typedef struct packed {
		uop_t             op;
		jcond_t           cond;
		logic [PC_W-1:0]  target;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		uop_t             op;
		logic [SEC_W-1:0] sec;
		logic             item;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic out_busy;
	} stat_t;

	// Program addresses that are jump targets
	localparam logic [PC_W-1:0] UC_IDLE   = 4'd0;
	localparam logic [PC_W-1:0] UC_P1_MUL = 4'd1;
	localparam logic [PC_W-1:0] UC_P2_MUL = 4'd4;
	localparam logic [PC_W-1:0] UC_OUT    = 4'd12;
	localparam logic [PC_W-1:0] UC_RET    = 4'd13;

	// Control store: one word per step
	function automatic uword_t ucode(input logic [PC_W-1:0] step);
		uword_t w;
		unique case (step)
			4'd0:    w = '{op: OP_LOADX,    cond: JC_NO_ITEM,       target: UC_IDLE};
			4'd1:    w = '{op: OP_SECT_MUL, cond: JC_NONE,          target: UC_IDLE};
			4'd2:    w = '{op: OP_SECT_FIN, cond: JC_PATH_NOT_DONE, target: UC_P1_MUL};
			4'd3:    w = '{op: OP_P1DONE,   cond: JC_NONE,          target: UC_IDLE};
			4'd4:    w = '{op: OP_SECT_MUL, cond: JC_NONE,          target: UC_IDLE};
			4'd5:    w = '{op: OP_SECT_FIN, cond: JC_PATH_NOT_DONE, target: UC_P2_MUL};
			4'd6:    w = '{op: OP_ROM_LO,   cond: JC_NONE,          target: UC_IDLE};
			4'd7:    w = '{op: OP_ROM_HI,   cond: JC_NONE,          target: UC_IDLE};
			4'd8:    w = '{op: OP_TRIG_HI,  cond: JC_NONE,          target: UC_IDLE};
			4'd9:    w = '{op: OP_MUL_C,    cond: JC_NONE,          target: UC_IDLE};
			4'd10:   w = '{op: OP_MUL_S,    cond: JC_NONE,          target: UC_IDLE};
			4'd11:   w = '{op: OP_SUB,      cond: JC_NONE,          target: UC_IDLE};
			4'd12:   w = '{op: OP_OUT,      cond: JC_OUT_BUSY,      target: UC_OUT};
			default: w = '{op: OP_NOP,      cond: JC_ALWAYS,        target: UC_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hass_sine_rom.sv -----
// Quarter-wave sine table with registered read.
`timescale 1ns / 1ps
`default_nettype none

module hass_sine_rom #(
	parameter int SINE_TABLE_DEPTH = hass_pkg::DEF_SINE_TABLE_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic [$clog2(SINE_TABLE_DEPTH):0]   addr,
	output logic      [hass_pkg::ROM_W-1:0]          data
);

	logic [hass_pkg::ROM_W-1:0] tbl [SINE_TABLE_DEPTH+1];

	// sin(pi/2*k/depth): Taylor series in Q30 to x^13, Q15 rounded half up, clamped
	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tbl
		localparam longint ArgQ30 = hass_pkg::HALF_PI_Q30 * k / SINE_TABLE_DEPTH;
		localparam longint ArgSq  = ArgQ30 * ArgQ30 / hass_pkg::ONE_Q30;
		localparam longint Term1  = -(ArgQ30 * ArgSq / hass_pkg::ONE_Q30) / 64'sd6;
		localparam longint Term2  = -(Term1 * ArgSq / hass_pkg::ONE_Q30) / 64'sd20;
		localparam longint Term3  = -(Term2 * ArgSq / hass_pkg::ONE_Q30) / 64'sd42;
		localparam longint Term4  = -(Term3 * ArgSq / hass_pkg::ONE_Q30) / 64'sd72;
		localparam longint Term5  = -(Term4 * ArgSq / hass_pkg::ONE_Q30) / 64'sd110;
		localparam longint Term6  = -(Term5 * ArgSq / hass_pkg::ONE_Q30) / 64'sd156;
		localparam longint SumQ30 = ArgQ30 + Term1 + Term2 + Term3 + Term4 + Term5 + Term6;
		localparam longint RndQ15 = (SumQ30 + 64'sd16384) >>> 15;
		localparam logic [hass_pkg::ROM_W-1:0] SinQ15 = (RndQ15 < 0)
			? hass_pkg::ROM_W'(0)
			: ((RndQ15 > 64'sd32767) ? hass_pkg::ROM_W'(32767) : hass_pkg::ROM_W'(RndQ15));
		assign tbl[k] = SinQ15;
	end

	always_ff @(posedge clk) begin
		data <= tbl[addr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hass_useq.sv -----
// Microcode sequencer: step counter, control store, section counter, jumps.
`timescale 1ns / 1ps
`default_nettype none

module hass_useq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire hass_pkg::stat_t stat,
	output hass_pkg::ctrl_t      ctrl
);

	logic [hass_pkg::PC_W-1:0]  pc_q;
	logic [hass_pkg::PC_W-1:0]  pc_d;
	logic [hass_pkg::SEC_W-1:0] sec_q;
	hass_pkg::uword_t           cw;
	logic                       fire;
	logic                       take;

	assign cw       = hass_pkg::ucode(pc_q);
	assign in_ready = (pc_q == hass_pkg::UC_IDLE);
	assign fire     = in_valid && in_ready;

	always_comb begin
		unique case (cw.cond)
			hass_pkg::JC_NONE:          take = 1'b0;
			hass_pkg::JC_ALWAYS:        take = 1'b1;
			hass_pkg::JC_NO_ITEM:       take = !fire;
			hass_pkg::JC_PATH_NOT_DONE: take = (sec_q[1:0] != 2'b11);
			hass_pkg::JC_OUT_BUSY:      take = stat.out_busy;
			default:                    take = 1'b0;
		endcase
		pc_d = take ? cw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= hass_pkg::UC_IDLE;
			sec_q <= '0;
		end else begin
			pc_q <= pc_d;
			if (cw.op == hass_pkg::OP_SECT_FIN) begin
				sec_q <= sec_q + 1'b1;
			end
		end
	end

	assign ctrl.op   = cw.op;
	assign ctrl.sec  = sec_q;
	assign ctrl.item = fire;

`ifndef SYNTHESIS
	a_sec_aligned_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == hass_pkg::UC_IDLE |-> sec_q == '0)
		else $error("section counter not aligned at idle");

	a_path_split: assert property (@(posedge clk) disable iff (!arst_n)
		cw.op == hass_pkg::OP_P1DONE |-> sec_q == hass_pkg::SEC_W'(hass_pkg::PATH_SECT))
		else $error("path one finished at wrong section");

	a_out_return: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == hass_pkg::OP_OUT && !stat.out_busy) |=> pc_q == hass_pkg::UC_RET)
		else $error("sequencer did not leave output step");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/hass_datapath.sv -----
// Datapath: shared multiplier, allpass section state, carrier phase, output register.
`timescale 1ns / 1ps
`default_nettype none

module hass_datapath #(
	parameter int PHASE_BITS       = hass_pkg::DEF_PHASE_BITS,
	parameter int SINE_TABLE_DEPTH = hass_pkg::DEF_SINE_TABLE_DEPTH,
	parameter int INTERNAL_WIDTH   = hass_pkg::DEF_INTERNAL_WIDTH
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire hass_pkg::ctrl_t                       ctrl,
	output hass_pkg::stat_t                            stat,
	input  wire logic signed [hass_pkg::SAMPLE_W-1:0]  sample_in,
	input  wire logic                                  cfg_fire,
	input  wire logic        [hass_pkg::CFG_W-1:0]     cfg_data,
	output logic             [$clog2(SINE_TABLE_DEPTH):0] rom_addr,
	input  wire logic        [hass_pkg::ROM_W-1:0]     rom_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic             [hass_pkg::OUT_W-1:0]     out_data
);

	localparam int IW = INTERNAL_WIDTH;
	localparam int AB = $clog2(SINE_TABLE_DEPTH);
	localparam int CW = hass_pkg::COEF_BITS;
	localparam int PW = IW + CW + 2;      // product
	localparam int SW = PW + 1;           // shifted-sample sum
	localparam int FB = IW - 3;           // fraction bits
	localparam int TW = hass_pkg::TRIG_W;

	localparam logic signed [PW-1:0] SECT_HALF = PW'(1) << (CW - 1);
	localparam logic signed [IW:0]   OUT_HALF  = (IW + 1)'(1) << (IW - 18);
	localparam logic signed [SW-1:0] SUM_HALF  = SW'(1) << (FB - 1);

	function automatic logic [15:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767) begin
			return 16'h7fff;
		end else if (v < -32'sd32768) begin
			return 16'h8000;
		end else begin
			return v[15:0];
		end
	endfunction

	// Section history, rotated one place per finished section
	logic signed [IW-1:0] sx1_q [hass_pkg::NSECT];
	logic signed [IW-1:0] sx2_q [hass_pkg::NSECT];
	logic signed [IW-1:0] sy1_q [hass_pkg::NSECT];
	logic signed [IW-1:0] sy2_q [hass_pkg::NSECT];

	logic signed [IW-1:0]         pdelay_q;
	logic        [PHASE_BITS-1:0] phase_q;
	logic        [hass_pkg::CFG_W-1:0] step_q;
	logic                         out_valid_q;
	logic        [hass_pkg::OUT_W-1:0] out_data_q;

	logic signed [IW-1:0] x_q;
	logic signed [IW-1:0] acc_q;
	logic signed [IW-1:0] imag_q;
	logic signed [PW-1:0] prod_q;
	logic signed [SW-1:0] sum_q;
	logic signed [TW-1:0] cos_q;
	logic signed [TW-1:0] sin_q;

	logic signed [IW-1:0] x_in;
	logic signed [CW:0]   mul_a;
	logic signed [IW:0]   mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] sect_rs;
	logic signed [IW+1:0] sect_rnd;
	logic signed [IW+2:0] sect_diff;
	logic signed [IW-1:0] sect_y;
	logic        [1:0]    quad;
	logic        [AB-1:0] idx;
	logic signed [TW-1:0] rom_val;
	logic                 out_load;
	logic signed [IW:0]   real_rs;
	logic signed [IW:0]   imag_rs;
	logic signed [17:0]   real_r;
	logic signed [17:0]   imag_r;
	logic signed [SW-1:0] sum_rs;
	logic signed [SW-FB-1:0] sum_r;

	assign x_in = IW'(sample_in) <<< (IW - 18);

	// Carrier phase: quadrant on top, table index below it
	assign quad     = phase_q[PHASE_BITS-1 -: 2];
	assign idx      = phase_q[PHASE_BITS-3 -: AB];
	assign rom_addr = (ctrl.op == hass_pkg::OP_ROM_HI)
		? (AB + 1)'(SINE_TABLE_DEPTH) - {1'b0, idx} : {1'b0, idx};
	assign rom_val  = signed'({2'b00, rom_data});

	// Shared multiplier operand select
	always_comb begin
		unique case (ctrl.op)
			hass_pkg::OP_SECT_MUL: begin
				mul_a = signed'({1'b0, hass_pkg::COEF[ctrl.sec]});
				mul_b = (IW + 1)'(acc_q) + (IW + 1)'(sy2_q[0]);
			end
			hass_pkg::OP_MUL_C: begin
				mul_a = (CW + 1)'(cos_q);
				mul_b = (IW + 1)'(acc_q);
			end
			hass_pkg::OP_MUL_S: begin
				mul_a = (CW + 1)'(sin_q);
				mul_b = (IW + 1)'(imag_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Section finish: round to internal format, subtract x(t-2), saturate
	assign sect_rs   = prod_q + SECT_HALF;
	assign sect_rnd  = sect_rs[PW-1:CW];
	assign sect_diff = (IW + 3)'(sect_rnd) - (IW + 3)'(sx2_q[0]);

	always_comb begin
		if ((&sect_diff[IW+2:IW-1]) || !(|sect_diff[IW+2:IW-1])) begin
			sect_y = sect_diff[IW-1:0];
		end else if (sect_diff[IW+2]) begin
			sect_y = {1'b1, {(IW-1){1'b0}}};
		end else begin
			sect_y = {1'b0, {(IW-1){1'b1}}};
		end
	end

	// Output rounding
	assign real_rs = (IW + 1)'(acc_q) + OUT_HALF;
	assign imag_rs = (IW + 1)'(imag_q) + OUT_HALF;
	assign real_r  = real_rs[IW -: 18];
	assign imag_r  = imag_rs[IW -: 18];
	assign sum_rs  = sum_q + SUM_HALF;
	assign sum_r   = sum_rs[SW-1:FB];

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_load      = (ctrl.op == hass_pkg::OP_OUT) && !stat.out_busy;

	// State with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < hass_pkg::NSECT; k++) begin
				sx1_q[k] <= '0;
				sx2_q[k] <= '0;
				sy1_q[k] <= '0;
				sy2_q[k] <= '0;
			end
			pdelay_q    <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				step_q <= cfg_data;
			end
			if (ctrl.op == hass_pkg::OP_SECT_FIN) begin
				for (int k = 0; k < hass_pkg::NSECT - 1; k++) begin
					sx1_q[k] <= sx1_q[k+1];
					sx2_q[k] <= sx2_q[k+1];
					sy1_q[k] <= sy1_q[k+1];
					sy2_q[k] <= sy2_q[k+1];
				end
				sx1_q[hass_pkg::NSECT-1] <= acc_q;
				sx2_q[hass_pkg::NSECT-1] <= sx1_q[0];
				sy1_q[hass_pkg::NSECT-1] <= sect_y;
				sy2_q[hass_pkg::NSECT-1] <= sy1_q[0];
			end
			if (ctrl.op == hass_pkg::OP_P1DONE) begin
				pdelay_q <= acc_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_q + PHASE_BITS'(step_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			hass_pkg::OP_LOADX: begin
				if (ctrl.item) begin
					x_q   <= x_in;
					acc_q <= x_in;
				end
			end
			hass_pkg::OP_SECT_MUL: prod_q <= mul_p;
			hass_pkg::OP_SECT_FIN: acc_q <= sect_y;
			hass_pkg::OP_P1DONE: begin
				imag_q <= pdelay_q;
				acc_q  <= x_q;
			end
			hass_pkg::OP_ROM_HI: begin
				// entry at idx: sine in even quadrants, cosine in odd
				if (!quad[0]) begin
					sin_q <= (quad[1] ^ quad[0]) ? -rom_val : rom_val;
				end else begin
					cos_q <= (quad[1] ^ quad[0]) ? -rom_val : rom_val;
				end
			end
			hass_pkg::OP_TRIG_HI: begin
				// entry at depth-idx: cosine in even quadrants, sine in odd
				if (!quad[0]) begin
					cos_q <= quad[1] ? -rom_val : rom_val;
				end else begin
					sin_q <= quad[1] ? -rom_val : rom_val;
				end
			end
			hass_pkg::OP_MUL_C: prod_q <= mul_p;
			hass_pkg::OP_MUL_S: begin
				sum_q  <= SW'(prod_q);
				prod_q <= mul_p;
			end
			hass_pkg::OP_SUB: sum_q <= sum_q - SW'(prod_q);
			hass_pkg::OP_OUT: begin
				if (out_load) begin
					out_data_q <= {sat16(32'(sum_r)), sat16(32'(imag_r)), sat16(32'(real_r))};
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hilbert_allpass_ssb_shifter_core.sv -----
// Top level of the allpass Hilbert transformer and SSB frequency shifter.
`timescale 1ns / 1ps
`default_nettype none

// Single-sideband shifter. Each input item is one signed Q1.15 sample; each
// result item carries the analytic signal (real part = half of allpass path
// two, imaginary part = half of path one delayed by one sample) and the shifted
// sample cos*path_two - sin*path_one_delayed, all rounded and saturated to 16
// bits. Both paths are four second-order allpass sections in Q3.21 with Q0.18
// coefficients. A small microprogram steps one shared multiplier through the
// eight sections, the two carrier products and the output rounding; a new item
// is accepted only once the program is back at its idle step. The schedule is
// set by the single multiplier (ten products) and the two steps (multiply,
// finish) of every section. The result sits in an output register, so the
// next item is accepted while it waits; the sequencer only holds at the output
// step if the previous result was not yet taken. phase_step (config channel)
// is added to the carrier phase after every item; the item uses the phase
// from before the step. Write it only when idle.
// SINE_TABLE_DEPTH must be a power of two; the sine table holds depth+1
// quarter-wave entries in logic.

module hilbert_allpass_ssb_shifter_core #(
	parameter int PHASE_BITS       = hass_pkg::DEF_PHASE_BITS,
	parameter int SINE_TABLE_DEPTH = hass_pkg::DEF_SINE_TABLE_DEPTH,
	parameter int INTERNAL_WIDTH   = hass_pkg::DEF_INTERNAL_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
	// result items
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // [15:0] real_part, [31:16] imag_part,
	                                         // [47:32] shifted_sample
	// phase_step register
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	hass_pkg::ctrl_t ctrl;
	hass_pkg::stat_t stat;
	logic [$clog2(SINE_TABLE_DEPTH):0] rom_addr;
	logic [hass_pkg::ROM_W-1:0]        rom_data;

	// config is always taken
	assign cfg_ready = 1'b1;

	hass_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	hass_datapath #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.INTERNAL_WIDTH   (INTERNAL_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.sample_in (s_axis_tdata),
		.cfg_fire  (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.rom_addr  (rom_addr),
		.rom_data  (rom_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	hass_sine_rom #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_sine_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

endmodule

`default_nettype wire
